// ===== src/usbt_pkg.sv =====
// usbt_pkg: shared types, constants and helpers for the uplink session backoff table
// used by the channel interfaces, the controller, the datapath and the top level
package usbt_pkg;

    localparam int ENTRIES   = 8;
    localparam int IDX_W     = $clog2(ENTRIES);
    localparam int CNT_W     = $clog2(ENTRIES + 1);
    localparam int STATION_W = 32;
    localparam int SESSION_W = 8;
    localparam int DIV_W     = 4;
    localparam int BACKOFF_W = 6;
    localparam int AP_W      = 16;
    localparam int MOD_CNT_W = $clog2(AP_W);

    localparam logic [DIV_W-1:0] DIV_MAX = DIV_W'(12);
    localparam logic [DIV_W-1:0] DIV_MIN = DIV_W'(6);

    typedef struct packed {
        logic [STATION_W-1:0] station;
        logic [SESSION_W-1:0] session;
        logic [DIV_W-1:0]     divisor;
    } entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MOD,
        ST_DONE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic rd_en;
        logic upd;
        logic mod_step;
        logic out_load;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic match;
        logic scan_more;
        logic rd_pending;
        logic mod_last;
    } status_t;

    function automatic logic [DIV_W-1:0] next_divisor(input logic [DIV_W-1:0] d);
        logic [DIV_W-1:0] r;
        if (d <= DIV_MIN || d > DIV_MAX)
            r = DIV_MAX;
        else
            r = d - DIV_W'(1);
        return r;
    endfunction

endpackage

// ===== src/usbt_if.sv =====
// usbt_if: valid/ready channel interfaces for requests, results and configuration
// depends on usbt_pkg for field widths

interface usbt_req_if;
    logic                            valid;
    logic                            ready;
    logic [usbt_pkg::STATION_W-1:0]  station_id;
    logic [usbt_pkg::SESSION_W-1:0]  session_num;

    modport source (output valid, output station_id, output session_num, input ready);
    modport sink   (input valid, input station_id, input session_num, output ready);
endinterface

interface usbt_rsp_if;
    logic                            valid;
    logic                            ready;
    logic                            found;
    logic                            replaced_oldest;
    logic [usbt_pkg::DIV_W-1:0]      spacing_divisor;
    logic [usbt_pkg::BACKOFF_W-1:0]  backoff_units;

    modport source (output valid, output found, output replaced_oldest,
                    output spacing_divisor, output backoff_units, input ready);
    modport sink   (input valid, input found, input replaced_oldest,
                    input spacing_divisor, input backoff_units, output ready);
endinterface

interface usbt_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [usbt_pkg::AP_W-1:0]       ap_id;

    modport source (output valid, output ap_id, input ready);
    modport sink   (input valid, input ap_id, output ready);
endinterface

// ===== src/usbt_ctrl.sv =====
// usbt_ctrl: sequencing state machine and result valid flag
// depends on usbt_pkg (state_t, cmd_t, status_t)
module usbt_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    input  usbt_pkg::status_t stat,
    output usbt_pkg::cmd_t    cmd
);

    usbt_pkg::state_t state_reg, state_next;
    logic             out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= usbt_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        case (state_reg)
            usbt_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = usbt_pkg::ST_SCAN;
                end
            end
            usbt_pkg::ST_SCAN:
            begin
                // hit, or miss once the last read has been compared
                if (stat.match)
                begin
                    cmd.upd    = 1'b1;
                    state_next = usbt_pkg::ST_MOD;
                end
                else if (stat.scan_more)
                    cmd.rd_en = 1'b1;
                else if (!stat.rd_pending)
                begin
                    cmd.upd    = 1'b1;
                    state_next = usbt_pkg::ST_MOD;
                end
            end
            usbt_pkg::ST_MOD:
            begin
                cmd.mod_step = 1'b1;
                if (stat.mod_last)
                    state_next = usbt_pkg::ST_DONE;
            end
            usbt_pkg::ST_DONE:
            begin
                if (!out_valid_reg || rsp_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = usbt_pkg::ST_IDLE;
                end
            end
            default:
                state_next = usbt_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (rsp_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign rsp_valid = out_valid_reg;

endmodule

// ===== src/usbt_datapath.sv =====
// usbt_datapath: station table memory, scan compare, update, remainder unit, result register
// depends on usbt_pkg (entry_t, cmd_t, status_t, widths, next_divisor)
module usbt_datapath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  usbt_pkg::cmd_t                  cmd,
    output usbt_pkg::status_t               stat,
    input  logic [usbt_pkg::STATION_W-1:0]  station_id,
    input  logic [usbt_pkg::SESSION_W-1:0]  session_num,
    input  logic                            cfg_we,
    input  logic [usbt_pkg::AP_W-1:0]       cfg_ap_id,
    output logic                            found,
    output logic                            replaced_oldest,
    output logic [usbt_pkg::DIV_W-1:0]      spacing_divisor,
    output logic [usbt_pkg::BACKOFF_W-1:0]  backoff_units
);

    usbt_pkg::entry_t mem [usbt_pkg::ENTRIES];

    logic [usbt_pkg::AP_W-1:0]       ap_id_reg;
    logic [usbt_pkg::STATION_W-1:0]  sid_reg;
    logic [usbt_pkg::SESSION_W-1:0]  ses_reg;
    logic [usbt_pkg::CNT_W-1:0]      idx_reg;
    logic [usbt_pkg::CNT_W-1:0]      count_reg;
    logic [usbt_pkg::IDX_W-1:0]      ptr_reg;
    usbt_pkg::entry_t                rd_reg;
    logic [usbt_pkg::IDX_W-1:0]      rd_idx_reg;
    logic                            rd_vld_reg;
    logic                            found_reg, repl_reg;
    logic [usbt_pkg::DIV_W-1:0]      div_reg;
    logic [usbt_pkg::DIV_W-1:0]      rem_reg;
    logic [usbt_pkg::AP_W-1:0]       apsh_reg;
    logic [usbt_pkg::MOD_CNT_W-1:0]  cnt_reg;

    logic                            full;
    logic [usbt_pkg::DIV_W-1:0]      new_div;
    logic [usbt_pkg::IDX_W-1:0]      wr_idx;
    logic [usbt_pkg::DIV_W:0]        shifted;
    logic [usbt_pkg::DIV_W-1:0]      rem_next;

    assign stat.match      = rd_vld_reg && (rd_reg.station == sid_reg);
    assign stat.scan_more  = idx_reg < count_reg;
    assign stat.rd_pending = rd_vld_reg;
    assign stat.mod_last   = cnt_reg == {usbt_pkg::MOD_CNT_W{1'b1}};

    assign full = count_reg == usbt_pkg::CNT_W'(usbt_pkg::ENTRIES);

    always_comb
    begin
        if (stat.match)
        begin
            wr_idx  = rd_idx_reg;
            new_div = (rd_reg.session == ses_reg) ?
                      usbt_pkg::next_divisor(rd_reg.divisor) : usbt_pkg::DIV_MAX;
        end
        else
        begin
            // oldest slot advances round robin once the table is full
            wr_idx  = full ? ptr_reg : count_reg[usbt_pkg::IDX_W-1:0];
            new_div = usbt_pkg::DIV_MAX;
        end
    end

    // restoring remainder, one dividend bit per step
    assign shifted  = {rem_reg, apsh_reg[usbt_pkg::AP_W-1]};
    assign rem_next = (shifted >= {1'b0, div_reg}) ?
                      usbt_pkg::DIV_W'(shifted - {1'b0, div_reg}) :
                      shifted[usbt_pkg::DIV_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
            rd_reg <= mem[idx_reg[usbt_pkg::IDX_W-1:0]];
        if (cmd.upd)
            mem[wr_idx] <= '{station: sid_reg, session: ses_reg, divisor: new_div};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ap_id_reg  <= '0;
            count_reg  <= '0;
            ptr_reg    <= '0;
            idx_reg    <= '0;
            rd_vld_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            rd_vld_reg <= cmd.rd_en;
            if (cfg_we)
                ap_id_reg <= cfg_ap_id;
            if (cmd.load)
                idx_reg <= '0;
            else if (cmd.rd_en)
                idx_reg <= idx_reg + usbt_pkg::CNT_W'(1);
            if (cmd.upd && !stat.match)
            begin
                if (full)
                    ptr_reg <= (ptr_reg == usbt_pkg::IDX_W'(usbt_pkg::ENTRIES - 1)) ?
                               '0 : ptr_reg + usbt_pkg::IDX_W'(1);
                else
                    count_reg <= count_reg + usbt_pkg::CNT_W'(1);
            end
            if (cmd.upd)
                cnt_reg <= '0;
            else if (cmd.mod_step)
                cnt_reg <= cnt_reg + usbt_pkg::MOD_CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sid_reg <= station_id;
            ses_reg <= session_num;
        end
        if (cmd.rd_en)
            rd_idx_reg <= idx_reg[usbt_pkg::IDX_W-1:0];
        if (cmd.upd)
        begin
            found_reg <= stat.match;
            repl_reg  <= !stat.match && full;
            div_reg   <= new_div;
            rem_reg   <= '0;
            apsh_reg  <= ap_id_reg;
        end
        else if (cmd.mod_step)
        begin
            rem_reg  <= rem_next;
            apsh_reg <= apsh_reg << 1;
        end
        if (cmd.out_load)
        begin
            found           <= found_reg;
            replaced_oldest <= repl_reg;
            spacing_divisor <= div_reg;
            backoff_units   <= {rem_reg, 2'b00};
        end
    end

endmodule

// ===== src/uplink_session_backoff_table.sv =====
// uplink_session_backoff_table: top level, joins controller and datapath to the channels
// depends on usbt_pkg, usbt_if, usbt_ctrl, usbt_datapath
//
// Usage: uplink requests (station_id, session_num) enter on req, one result per
// request leaves on rsp (found, replaced_oldest, spacing_divisor, backoff_units).
// The ap_id register is written on cfg, which is always ready; write it only
// while no request is in progress.
// One request is handled at a time. The table memory is scanned one slot per
// cycle behind a registered read, until a hit or until all N occupied slots (at
// most ENTRIES) have been compared; then the table is updated and the remainder
// ap_id mod divisor is formed one dividend bit per cycle. The next request can
// transfer only after the result is loaded.
// req is ready again once the result is loaded into the output register, so
// the next request is taken while a result still waits on rsp. If the receiver
// stalls, the next finished result waits inside until the output register frees.
// Reset empties the table (occupancy count and oldest pointer cleared), clears
// ap_id and drops any pending result; table contents are not cleared.
module uplink_session_backoff_table (
    input  logic       clk,
    input  logic       rst_n,
    usbt_cfg_if.sink   cfg,
    usbt_req_if.sink   req,
    usbt_rsp_if.source rsp
);

    usbt_pkg::cmd_t    cmd;
    usbt_pkg::status_t stat;

    assign cfg.ready = 1'b1;

    usbt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    usbt_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .station_id      (req.station_id),
        .session_num     (req.session_num),
        .cfg_we          (cfg.valid),
        .cfg_ap_id       (cfg.ap_id),
        .found           (rsp.found),
        .replaced_oldest (rsp.replaced_oldest),
        .spacing_divisor (rsp.spacing_divisor),
        .backoff_units   (rsp.backoff_units)
    );

    a_div_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.spacing_divisor >= usbt_pkg::DIV_MIN &&
                       rsp.spacing_divisor <= usbt_pkg::DIV_MAX))
        else $error("spacing divisor out of range");

    a_backoff_below_div: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.backoff_units[1:0] == 2'b00 &&
                       rsp.backoff_units[5:2] < rsp.spacing_divisor))
        else $error("backoff not a scaled remainder of the divisor");

    a_hit_not_replace: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> !(rsp.found && rsp.replaced_oldest))
        else $error("hit reported together with replacement");

    a_single_update: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.upd |=> !cmd.upd)
        else $error("table updated twice for one request");

endmodule
